// ----- hw/rtl/bst_pkg.sv -----
// Package for the bounded set table: field widths, operation codes and the
// command/status structs between controller and datapath. No dependencies.
package bst_pkg;

  localparam int FUNC_W = 2;
  localparam int KEY_W  = 64;
  localparam int CNT_W  = 7;

  localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT = 2'd0,
    FN_REMOVE = 2'd1,
    FN_QUERY  = 2'd2,
    FN_COUNT  = 2'd3
  } func_t;

  // Controller to datapath
  typedef struct packed {
    logic load;     // capture key, restart scan
    logic scan;     // advance scan by one entry
    logic take;     // record slot of the current hit
    logic rd_last;  // read the last used entry
    logic ins;      // append key, grow count
    logic mov;      // move last entry into hit slot, shrink count
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic             hit;
    logic             searched;
    logic             room;
    logic [CNT_W-1:0] count;
  } status_t;

endpackage

// ----- hw/rtl/bst_if.sv -----
// Handshake channels of the bounded set table: request and response.
// Depends on bst_pkg for field widths.
interface bst_req_if;
  logic                        valid;
  logic                        ready;
  logic [bst_pkg::FUNC_W-1:0]  func;
  logic [bst_pkg::KEY_W-1:0]   key_value;

  modport source (output valid, output func, output key_value, input ready);
  modport sink   (input valid, input func, input key_value, output ready);
endinterface

interface bst_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        success;
  logic [bst_pkg::CNT_W-1:0]   fill_count;

  modport source (output valid, output success, output fill_count, input ready);
  modport sink   (input valid, input success, input fill_count, output ready);
endinterface

// ----- hw/rtl/bst_dp.sv -----
// Datapath of the bounded set table: key memory, scan counter, compare,
// held count. Depends on bst_pkg; driven by bst_ctrl commands.
module bst_dp #(
  parameter int DEPTH = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  bst_pkg::cmd_t                cmd,
  input  logic [bst_pkg::KEY_W-1:0]    key_in,
  input  logic [bst_pkg::CNT_W-1:0]    capacity,
  output bst_pkg::status_t             status
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [bst_pkg::KEY_W-1:0] key_store [DEPTH];
  logic [bst_pkg::KEY_W-1:0] key_reg;
  logic [bst_pkg::KEY_W-1:0] rdata;
  logic [bst_pkg::CNT_W-1:0] count;
  logic [bst_pkg::CNT_W-1:0] idx;
  logic [bst_pkg::CNT_W-1:0] pend_idx;
  logic [bst_pkg::CNT_W-1:0] slot;
  logic                      pend;
  logic                      hit;
  logic [AW-1:0]             rd_addr;
  logic [AW-1:0]             wr_addr;
  logic [bst_pkg::KEY_W-1:0] wr_data;

  assign hit     = pend && (rdata == key_reg);
  assign rd_addr = cmd.rd_last ? AW'(count - 7'd1) : AW'(idx);
  assign wr_addr = cmd.mov ? AW'(slot) : AW'(count);
  assign wr_data = cmd.mov ? rdata : key_reg;

  always_ff @(posedge clk) begin
    rdata <= key_store[rd_addr];
    if (cmd.ins || cmd.mov) begin
      key_store[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_reg <= key_in;
    end
    if (cmd.take) begin
      slot <= pend_idx;
    end
    if (cmd.scan && idx < count) begin
      pend_idx <= idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      idx   <= '0;
      pend  <= 1'b0;
    end else begin
      if (cmd.load) begin
        idx  <= '0;
        pend <= 1'b0;
      end else if (cmd.scan) begin
        if (idx < count) begin
          idx  <= idx + 7'd1;
          pend <= 1'b1;
        end else begin
          pend <= 1'b0;
        end
      end
      if (cmd.ins) begin
        count <= count + 7'd1;
      end else if (cmd.mov) begin
        count <= count - 7'd1;
      end
    end
  end

  assign status.hit      = hit;
  assign status.searched = (idx >= count) && !hit;
  assign status.room     = (count < capacity) && (int'(count) < DEPTH);
  assign status.count    = count;

endmodule

// ----- hw/rtl/bst_ctrl.sv -----
// Controller of the bounded set table: sequences scan, insert and remove,
// and holds the response register. Depends on bst_pkg and bst_if.
module bst_ctrl (
  input  logic              clk,
  input  logic              rst,
  bst_req_if.sink           req,
  bst_rsp_if.source         rsp,
  output bst_pkg::cmd_t     cmd,
  input  bst_pkg::status_t  status
);

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_SCAN    = 5'b00010,
    S_MOVE_RD = 5'b00100,
    S_MOVE_WR = 5'b01000,
    S_DONE    = 5'b10000
  } state_t;

  state_t                     state, state_next;
  bst_pkg::func_t             func, func_next;
  logic                       ok, ok_next;
  logic                       rsp_valid, rsp_valid_next;
  logic                       rsp_success;
  logic [bst_pkg::CNT_W-1:0]  rsp_fill;
  logic                       push;

  assign req.ready      = (state == S_IDLE);
  assign rsp.valid      = rsp_valid;
  assign rsp.success    = rsp_success;
  assign rsp.fill_count = rsp_fill;

  assign push = (state == S_DONE) && (!rsp_valid || rsp.ready);

  always_comb begin
    state_next = state;
    func_next  = func;
    ok_next    = ok;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          cmd.load  = 1'b1;
          func_next = bst_pkg::func_t'(req.func);
          ok_next   = 1'b0;
          state_next = (bst_pkg::func_t'(req.func) == bst_pkg::FN_COUNT) ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        priority if (status.hit) begin
          cmd.take = 1'b1;
          unique case (func)
            bst_pkg::FN_REMOVE: begin
              ok_next    = 1'b1;
              state_next = S_MOVE_RD;
            end
            bst_pkg::FN_QUERY: begin
              ok_next    = 1'b1;
              state_next = S_DONE;
            end
            default: begin
              ok_next    = 1'b0;
              state_next = S_DONE;
            end
          endcase
        end else if (status.searched) begin
          // key absent: only an insert with room changes the table
          if (func == bst_pkg::FN_INSERT && status.room) begin
            cmd.ins = 1'b1;
            ok_next = 1'b1;
          end else begin
            ok_next = 1'b0;
          end
          state_next = S_DONE;
        end else begin
          cmd.scan = 1'b1;
        end
      end
      S_MOVE_RD: begin
        cmd.rd_last = 1'b1;
        state_next  = S_MOVE_WR;
      end
      S_MOVE_WR: begin
        cmd.mov    = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (push) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    rsp_valid_next = rsp_valid && !rsp.ready;
    if (push) begin
      rsp_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      func      <= bst_pkg::FN_COUNT;
      ok        <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
      func      <= func_next;
      ok        <= ok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      rsp_success <= ok;
      rsp_fill    <= status.count;
    end
  end

endmodule

// ----- hw/rtl/bounded_set_table_top.sv -----
// Top level of the bounded set table: capacity register on an APB-style port,
// controller and datapath. Depends on bst_pkg, bst_if, bst_ctrl, bst_dp.
//
// Usage: a request item carries func (insert, remove, query, read count) and
// a 64-bit key; each request yields exactly one response item with success
// and the number of keys held after the operation. Keys are distinct and
// compared bit for bit; a remove fills the freed slot with the last entry.
// Items are handled one at a time. Scanning reads one key store entry per
// cycle through the single read port; a remove that finds its key then
// reads the last entry and writes it into the freed slot. A read count
// item skips the scan and goes straight to the response register.
// The response sits in an output register: the next request is accepted
// while it waits, and a stalled receiver holds the block only once the next
// response is ready too. Reset empties the table and sets capacity to 64;
// the key store itself is not cleared. Write capacity only while idle.
module bounded_set_table_top #(
  parameter int DEPTH = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  bst_req_if.sink                    req,
  bst_rsp_if.source                  rsp,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [1:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  logic [bst_pkg::CNT_W-1:0] capacity;
  bst_pkg::cmd_t             cmd;
  bst_pkg::status_t          status;

  // single register: every word address decodes to capacity
  assign pready = 1'b1;
  assign prdata = {25'd0, capacity};

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= bst_pkg::CAP_RESET;
    end else if (psel && penable && pwrite && (paddr == 2'd0 || paddr != 2'd0)) begin
      capacity <= pwdata[bst_pkg::CNT_W-1:0];
    end
  end

  bst_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .rsp    (rsp),
    .cmd    (cmd),
    .status (status)
  );

  bst_dp #(.DEPTH(DEPTH)) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .key_in   (req.key_value),
    .capacity (capacity),
    .status   (status)
  );

  a_ins_room: assert property (@(posedge clk) disable iff (rst)
    cmd.ins |-> status.room)
    else $error("insert without room");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("second item accepted while busy");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (status.count == $past(status.count) ||
              status.count == 7'($past(status.count) + 7'd1) ||
              status.count == 7'($past(status.count) - 7'd1)))
    else $error("held count jumped");

  a_mov_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.mov |-> (status.count != '0))
    else $error("move on empty table");

endmodule
